FILE: hw/rtl/sm3_pkg.sv
// sm3 package: controller commands, status and sm3 constants
// used by sm3_ctrl, sm3_dp and sm3_hash_engine_top
package sm3_pkg;

    localparam logic [31:0] T_LOW    = 32'h79cc4519;
    localparam logic [31:0] T_HIGH   = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [255:0] IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    typedef enum logic [2:0] {
        S_IN,
        S_PAD,
        S_LEN_HI,
        S_LEN_LO,
        S_RUN,
        S_FOLD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        WSEL_DATA,
        WSEL_ZERO,
        WSEL_LEN_HI,
        WSEL_LEN_LO
    } t_wsel;

    typedef struct packed {
        logic  push;
        t_wsel wsel;
        logic  take_in;
        logic  round;
        logic  fold;
        logic  restart;
        logic  out_shift;
    } t_cmd;

    typedef struct packed {
        logic       block_full;
        logic [3:0] word_pos;
        logic       round_last;
    } t_sts;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

FILE: hw/rtl/sm3_dp.sv
// sm3 datapath: block buffer, message expansion window, one round per cycle,
// length counter, chaining value and digest shift register; uses sm3_pkg
module sm3_dp
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_data,
    input  logic [2:0]  i_count,
    input  logic        i_last,
    output t_sts        o_sts,
    output logic [31:0] o_digest
);

    logic [31:0] r_win [16];
    logic [31:0] r_v   [8];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [3:0]  r_pos;
    logic [5:0]  r_round;
    logic [63:0] r_bits;
    logic [31:0] r_out [8];

    logic [2:0]  w_cnt;
    logic [31:0] w_mask, w_data_word, w_word;
    logic [31:0] w_new, w_wj, w_wj4, w_ff, w_gg, w_t, w_a12, w_ss1, w_ss2, w_tt1, w_tt2;
    logic [63:0] n_bits;

    always_comb begin
        w_cnt = (!i_last || i_count > 3'd4) ? 3'd4 : i_count;
        case (w_cnt)
            3'd0:    w_mask = 32'h0;
            3'd1:    w_mask = 32'hFF000000;
            3'd2:    w_mask = 32'hFFFF0000;
            3'd3:    w_mask = 32'hFFFFFF00;
            default: w_mask = 32'hFFFFFFFF;
        endcase
        w_data_word = (i_data & w_mask);
        if (i_last && w_cnt != 3'd4) begin
            w_data_word = w_data_word | ({PAD_BYTE, 24'h0} >> {w_cnt, 3'b000});
        end
        n_bits = r_bits + {58'd0, w_cnt, 3'b000};
        case (i_cmd.wsel)
            WSEL_DATA:   w_word = w_data_word;
            WSEL_ZERO:   w_word = 32'h0;
            WSEL_LEN_HI: w_word = r_bits[63:32];
            default:     w_word = r_bits[31:0];
        endcase
    end

    // pad word after a full last word is selected by controller as zero with 0x80
    logic [31:0] w_push;
    assign w_push = (i_cmd.wsel == WSEL_ZERO && i_cmd.take_in) ?
                    {PAD_BYTE, 24'h0} : w_word;

    // round logic; window holds w[j..j+15] at index 0..15
    always_comb begin
        w_wj  = r_win[0];
        w_wj4 = r_win[4];
        w_new = p1(r_win[0] ^ r_win[7] ^ rotl(r_win[13], 5'd15)) ^
                rotl(r_win[3], 5'd7) ^ r_win[10];
        if (r_round < 6'd16) begin
            w_ff = r_a ^ r_b ^ r_c;
            w_gg = r_e ^ r_f ^ r_g;
            w_t  = T_LOW;
        end else begin
            w_ff = (r_a & r_b) | (r_a & r_c) | (r_b & r_c);
            w_gg = (r_e & r_f) | (~r_e & r_g);
            w_t  = T_HIGH;
        end
        w_a12 = rotl(r_a, 5'd12);
        w_ss1 = rotl(w_a12 + r_e + rotl(w_t, r_round[4:0]), 5'd7);
        w_ss2 = w_ss1 ^ w_a12;
        w_tt1 = w_ff + r_d + w_ss2 + (w_wj ^ w_wj4);
        w_tt2 = w_gg + r_h + w_ss1 + w_wj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'd0;
            r_bits  <= 64'd0;
            r_round <= 6'd0;
            for (int k = 0; k < 8; k++) r_v[k] <= IV[255-32*k -: 32];
        end else begin
            if (i_cmd.push) begin
                r_win[r_pos] <= w_push;
                r_pos        <= r_pos + 4'd1;
                if (i_cmd.take_in && i_cmd.wsel == WSEL_DATA) r_bits <= n_bits;
                if (r_pos == 4'd15) begin
                    r_a <= r_v[0]; r_b <= r_v[1]; r_c <= r_v[2]; r_d <= r_v[3];
                    r_e <= r_v[4]; r_f <= r_v[5]; r_g <= r_v[6]; r_h <= r_v[7];
                    r_round <= 6'd0;
                end
            end
            if (i_cmd.round) begin
                for (int k = 0; k < 15; k++) r_win[k] <= r_win[k+1];
                r_win[15] <= w_new;
                r_d <= r_c; r_c <= rotl(r_b, 5'd9); r_b <= r_a; r_a <= w_tt1;
                r_h <= r_g; r_g <= rotl(r_f, 5'd19); r_f <= r_e; r_e <= p0(w_tt2);
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.fold) begin
                r_v[0] <= r_v[0] ^ r_a; r_v[1] <= r_v[1] ^ r_b;
                r_v[2] <= r_v[2] ^ r_c; r_v[3] <= r_v[3] ^ r_d;
                r_v[4] <= r_v[4] ^ r_e; r_v[5] <= r_v[5] ^ r_f;
                r_v[6] <= r_v[6] ^ r_g; r_v[7] <= r_v[7] ^ r_h;
            end
            if (i_cmd.restart) begin
                r_out[0] <= r_v[0] ^ r_a; r_out[1] <= r_v[1] ^ r_b;
                r_out[2] <= r_v[2] ^ r_c; r_out[3] <= r_v[3] ^ r_d;
                r_out[4] <= r_v[4] ^ r_e; r_out[5] <= r_v[5] ^ r_f;
                r_out[6] <= r_v[6] ^ r_g; r_out[7] <= r_v[7] ^ r_h;
                for (int k = 0; k < 8; k++) r_v[k] <= IV[255-32*k -: 32];
                r_bits <= 64'd0;
                r_pos  <= 4'd0;
            end else if (i_cmd.out_shift) begin
                for (int k = 0; k < 7; k++) r_out[k] <= r_out[k+1];
            end
        end
    end

    assign o_sts.block_full = (r_pos == 4'd15);
    assign o_sts.word_pos   = r_pos;
    assign o_sts.round_last = (r_round == 6'd63);
    assign o_digest         = r_out[0];

endmodule

FILE: hw/rtl/sm3_ctrl.sv
// sm3 controller: sequences input, padding, length words, rounds and output
// uses sm3_pkg, drives sm3_dp through t_cmd
module sm3_ctrl
    import sm3_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    input  logic [2:0] i_in_count,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_out_index,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_final, n_final;
    logic   r_padfull, n_padfull;
    logic [2:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IN;
            r_ret     <= S_IN;
            r_final   <= 1'b0;
            r_padfull <= 1'b0;
            r_idx     <= 3'd0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_final   <= n_final;
            r_padfull <= n_padfull;
            r_idx     <= n_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_final   = r_final;
        n_padfull = r_padfull;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_cmd.wsel = WSEL_DATA;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IN: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.take_in = 1'b1;
                    if (i_in_last) begin
                        n_padfull = (i_in_count >= 3'd4);
                        n_ret     = n_padfull ? S_PAD :
                                    (i_sts.word_pos == 4'd13) ? S_LEN_HI : S_PAD;
                        if (!n_padfull && i_sts.word_pos == 4'd14) n_ret = S_PAD;
                    end else begin
                        n_ret = S_IN;
                    end
                    n_state = i_sts.block_full ? S_RUN : n_ret;
                end
            end
            S_PAD: begin
                // first pad word carries 0x80 when last word was full
                o_cmd.push    = 1'b1;
                o_cmd.wsel    = WSEL_ZERO;
                o_cmd.take_in = r_padfull;
                n_padfull     = 1'b0;
                n_ret = (i_sts.word_pos == 4'd13) ? S_LEN_HI : S_PAD;
                n_state = i_sts.block_full ? S_RUN : n_ret;
            end
            S_LEN_HI: begin
                o_cmd.push = 1'b1;
                o_cmd.wsel = WSEL_LEN_HI;
                n_state    = S_LEN_LO;
            end
            S_LEN_LO: begin
                o_cmd.push = 1'b1;
                o_cmd.wsel = WSEL_LEN_LO;
                n_final    = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) n_state = S_FOLD;
            end
            S_FOLD: begin
                if (r_final) begin
                    o_cmd.restart = 1'b1;
                    n_final = 1'b0;
                    n_idx   = 3'd0;
                    n_state = S_OUT;
                end else begin
                    o_cmd.fold = 1'b1;
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_shift = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = S_IN;
                    end
                end
            end
            default: n_state = S_IN;
        endcase
    end

    assign o_out_index = r_idx;

endmodule

FILE: hw/rtl/sm3_hash_engine_top.sv
// sm3 hash engine top level: joins sm3_ctrl and sm3_dp
// uses sm3_pkg
//
// input channel: s_axis, tdata = data_word, tuser = {last_word, byte_count}
// (byte_count bits 2:0, last_word bit 3). output channel: m_axis, tdata =
// digest_word, tuser = {last_digest, word_index}.
// each input word is written into the block buffer; the 16th word of a
// block starts 64 rounds of the compression, one per cycle, then a fold
// into the chaining value (for the last block, into the digest words).
// on the last word the engine appends padding and the 64-bit length,
// using a second block if needed, then offers the eight digest words in
// order. input is not taken while a block compresses or digest words are
// pending. a stalled receiver simply holds the current digest word.
// reset (synchronous, active low) loads the initial value, clears the
// length and word position, and drops any pending digest.
module sm3_hash_engine_top
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_word
    input  logic [3:0]  s_axis_tuser,   // byte_count[2:0], last_word[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [3:0]  m_axis_tuser    // word_index[2:0], last_digest[3]
);

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [2:0] w_idx;

    sm3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tuser[3]),
        .i_in_count  (s_axis_tuser[2:0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_index (w_idx),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sm3_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_data   (s_axis_tdata),
        .i_count  (s_axis_tuser[2:0]),
        .i_last   (s_axis_tuser[3]),
        .o_sts    (w_sts),
        .o_digest (m_axis_tdata)
    );

    assign m_axis_tuser = {(w_idx == 3'd7), w_idx};

endmodule

FILE: tb/tb.sv
// testbench for sm3_hash_engine_top: streams messages, predicts digests in a local sm3 model
// depends on sm3_pkg (initial value and round constants) and the rtl top level
module tb
    import sm3_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // data_word
    logic [3:0]  s_axis_tuser;   // byte_count[2:0], last_word[3]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word
    logic [3:0]  m_axis_tuser;   // word_index[2:0], last_digest[3]

    sm3_hash_engine_top dut (.*);

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } t_digest;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
        logic        has_exp;
        logic [31:0] exp0;
    } t_row;

    logic [31:0] hv[8];
    logic [31:0] blk[16];
    int          wpos;
    logic [63:0] msg_bits;
    t_digest     digest_q[$];
    int          errors;
    int          cycles;

    function automatic logic [31:0] rl(logic [31:0] x, int n);
        n = n % 32;
        if (n == 0) return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w[68];
        logic [31:0] a, b, c, d, e, f, g, h, ss1, ss2, tt1, tt2, ff, gg, a12, tc;
        for (int j = 0; j < 16; j++) w[j] = blk[j];
        for (int j = 16; j < 68; j++) begin
            logic [31:0] t;
            t = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
            w[j] = (t ^ rl(t, 15) ^ rl(t, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
        end
        {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
        for (int j = 0; j < 64; j++) begin
            if (j < 16) begin
                ff = a ^ b ^ c; gg = e ^ f ^ g; tc = T_LOW;
            end else begin
                ff = (a & b) | (a & c) | (b & c); gg = (e & f) | (~e & g); tc = T_HIGH;
            end
            a12 = rl(a, 12);
            ss1 = rl(a12 + e + rl(tc, j), 7);
            ss2 = ss1 ^ a12;
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rl(b, 9); b = a; a = tt1;
            h = g; g = rl(f, 19); f = e;
            e = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
        end
        hv[0] ^= a; hv[1] ^= b; hv[2] ^= c; hv[3] ^= d;
        hv[4] ^= e; hv[5] ^= f; hv[6] ^= g; hv[7] ^= h;
    endtask

    task automatic load_word(logic [31:0] w);
        blk[wpos] = w;
        wpos++;
        if (wpos == 16) begin
            compress();
            wpos = 0;
        end
    endtask

    task automatic restart_hash();
        for (int k = 0; k < 8; k++) hv[k] = IV[255 - 32*k -: 32];
        wpos = 0;
        msg_bits = '0;
    endtask

    task automatic predict_word(logic [31:0] data, logic [2:0] cnt, logic last);
        int n;
        logic [31:0] mask;
        if (!last) begin
            msg_bits += 32;
            load_word(data);
            return;
        end
        n = (cnt > 4) ? 4 : cnt;
        msg_bits += n * 8;
        if (n == 4) begin
            load_word(data);
            load_word({PAD_BYTE, 24'h0});
        end else begin
            mask = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8*n));
            load_word((data & mask) | (32'(PAD_BYTE) << (24 - 8*n)));
        end
        if (wpos > 14) load_word(32'h0);
        while (wpos < 14) load_word(32'h0);
        load_word(msg_bits[63:32]);
        load_word(msg_bits[31:0]);
        for (int k = 0; k < 8; k++) digest_q.push_back({hv[k], 3'(k), k == 7});
        restart_hash();
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= {last, cnt};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(data, cnt, last);
    endtask

    // receiver: random stalls, check each accepted digest word
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t unexpected digest word: actual %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    t_digest ex;
                    ex = digest_q.pop_front();
                    if (ex.word !== m_axis_tdata || ex.idx !== m_axis_tuser[2:0]
                            || ex.fin !== m_axis_tuser[3]) begin
                        $display("%0t digest mismatch: expected %h/%0d/%0d actual %h/%0d/%0d",
                            $time, ex.word, ex.idx, ex.fin, m_axis_tdata,
                            m_axis_tuser[2:0], m_axis_tuser[3]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("status: fail");
            $finish;
        end
    end

    t_row rows[$];
    int   nwords;
    logic [31:0] d;

    initial begin
        errors = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        restart_hash();
        // empty message, known digest word 0
        rows.push_back('{32'hdeadbeef, 3'd0, 1'b1, 1'b1, 32'h1ab21d83});
        // "abc", known digest word 0
        rows.push_back('{32'h616263ff, 3'd3, 1'b1, 1'b1, 32'h66c7f0f4});
        rows.push_back('{32'hffffffff, 3'd7, 1'b1, 1'b0, 32'h0});
        rows.push_back('{32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0});
        rows.push_back('{32'h12345678, 3'd5, 1'b0, 1'b0, 32'h0});
        rows.push_back('{32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0});
        rows.push_back('{32'haabbccdd, 3'd2, 1'b1, 1'b0, 32'h0});
        // 13 to 16 full words then last: with 14 or more the padding spills into a second block
        for (int m = 13; m <= 16; m++) begin
            for (int k = 0; k < m; k++)
                rows.push_back('{$urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0, 32'h0});
            rows.push_back('{$urandom, 3'(m - 13), 1'b1, 1'b0, 32'h0});
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[r]) begin
            if (rows[r].has_exp) begin
                send_word(rows[r].data, rows[r].cnt, rows[r].last);
                if (digest_q[digest_q.size() - 8].word !== rows[r].exp0) begin
                    $display("%0t known digest mismatch: expected %h actual %h", $time,
                        rows[r].exp0, digest_q[digest_q.size() - 8].word);
                    errors++;
                end
            end else begin
                send_word(rows[r].data, rows[r].cnt, rows[r].last);
            end
        end
        nwords = 0;
        while (nwords < 150) begin
            int len;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 10);
            for (int k = 0; k < len; k++) begin
                d = $urandom;
                send_word(d, 3'($urandom_range(0, 7)), 1'b0);
            end
            d = $urandom;
            send_word(d, 3'($urandom_range(0, 7)), 1'b1);
            nwords += len + 1;
        end
        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: sm3_hash_engine_top.f
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_dp.sv
hw/rtl/sm3_ctrl.sv
hw/rtl/sm3_hash_engine_top.sv
tb/tb.sv
